[hdl/msc_pkg.sv]
// Shared types, constants and saturating arithmetic for the 2x2 matrix scaling pipeline.
`default_nettype none

package msc_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned MUL_LAT = 5;

	typedef logic signed [WORD_W-1:0] q64_t;
	typedef logic signed [DATA_W-1:0] q32_t;

	localparam q64_t Q64_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam q64_t Q64_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam q32_t Q32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam q32_t Q32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	// Root width of the square root pipeline, which has one stage per root bit.
	function automatic int sqrt_lat(input int frac);
		return (WORD_W + frac + 1) / 2;
	endfunction

	// Stage count of the divider: a prepare stage, one stage per quotient bit, a result stage.
	function automatic int div_lat(input int frac);
		return WORD_W + frac + 1;
	endfunction

	function automatic q64_t sat_add(input q64_t x, input q64_t y);
		logic signed [WORD_W:0] s;
		s = {x[WORD_W-1], x} + {y[WORD_W-1], y};
		if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? Q64_MIN : Q64_MAX;
		return s[WORD_W-1:0];
	endfunction

	function automatic q64_t sat_sub(input q64_t x, input q64_t y);
		logic signed [WORD_W:0] s;
		s = {x[WORD_W-1], x} - {y[WORD_W-1], y};
		if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? Q64_MIN : Q64_MAX;
		return s[WORD_W-1:0];
	endfunction

	function automatic q64_t sat_neg(input q64_t x);
		return (x == Q64_MIN) ? Q64_MAX : -x;
	endfunction

	function automatic q64_t sat_dbl(input q64_t x);
		if (x[WORD_W-1] != x[WORD_W-2]) return x[WORD_W-1] ? Q64_MIN : Q64_MAX;
		return {x[WORD_W-2:0], 1'b0};
	endfunction

	function automatic q32_t sat_out32(input q64_t x);
		if ((&x[WORD_W-1:DATA_W-1]) || !(|x[WORD_W-1:DATA_W-1])) return x[DATA_W-1:0];
		return x[WORD_W-1] ? Q32_MIN : Q32_MAX;
	endfunction

	function automatic q64_t ext64(input q32_t x);
		return {{(WORD_W-DATA_W){x[DATA_W-1]}}, x};
	endfunction

endpackage

`default_nettype wire

[hdl/matrix_scale_2x2_closed_form.sv]
// Top level: closed-form scaling of a 2x2 matrix to given first-column and row sums.
// Usage: one item on s_axis carries the four matrix entries and the three targets,
// all signed fixed point with FRAC_BITS fraction bits. For each accepted item one
// result appears on m_axis: the scaled matrix and a status flag in m_axis_tuser.
// Status 1 means the leading coefficient is zero or the discriminant is negative;
// the four entries are then zero.
// Throughput: one item per cycle while the output buffer is not full. The datapath
// is a single stall-together pipeline of three multiplier banks (5 stages each), a
// square root with one stage per root bit and two dividers with one stage per
// quotient bit.
// Results land in a two-entry output buffer. While the receiver stalls, the pipeline
// keeps taking items until that buffer is full, then holds with s_axis_tready low;
// nothing is dropped or repeated. Reset empties the buffer and clears all valid bits.
`default_nettype none

module matrix_scale_2x2_closed_form
	import msc_pkg::*;
#(
	parameter int FRAC_BITS = 24
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// entry_top_left, entry_top_right, entry_bottom_left, entry_bottom_right,
	// col_target_first, row_target_first, row_target_second (32 bits each)
	input  wire logic [223:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// out_top_left, out_top_right, out_bottom_left, out_bottom_right (32 bits each)
	output logic      [127:0] m_axis_tdata,
	// status
	output logic              m_axis_tuser
);

	localparam int SQRT_LAT = sqrt_lat(FRAC_BITS);
	localparam int DIV_LAT  = div_lat(FRAC_BITS);
	localparam int ML       = int'(MUL_LAT);
	localparam int TAIL_LAT = 2 * ML + SQRT_LAT + DIV_LAT + 5;
	localparam int LAT      = 3 * ML + SQRT_LAT + DIV_LAT + 9;
	localparam int RES_W    = 4 * DATA_W + 1;

	logic ce;
	logic [LAT:0] vld_s;

	// Input registers.
	q32_t a_s1, b_s1, c_s1, d_s1, c0_s1, r0_s1, r1_s1;

	always_ff @(posedge clk) begin
		if (ce) begin
			a_s1  <= s_axis_tdata[31:0];
			b_s1  <= s_axis_tdata[63:32];
			c_s1  <= s_axis_tdata[95:64];
			d_s1  <= s_axis_tdata[127:96];
			c0_s1 <= s_axis_tdata[159:128];
			r0_s1 <= s_axis_tdata[191:160];
			r1_s1 <= s_axis_tdata[223:192];
		end
	end

	// First multiplier bank: ad, bc and r0*c0.
	q64_t ad_m, bc_m, rc_m;
	logic [3*DATA_W-1:0] tgt_d1, tgt_d8;

	msc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_ad (
		.clk(clk), .ce(ce), .x(ext64(a_s1)), .y(ext64(d_s1)), .p(ad_m));
	msc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_bc (
		.clk(clk), .ce(ce), .x(ext64(b_s1)), .y(ext64(c_s1)), .p(bc_m));
	msc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_rc (
		.clk(clk), .ce(ce), .x(ext64(r0_s1)), .y(ext64(c0_s1)), .p(rc_m));

	msc_delay #(.WIDTH(3 * DATA_W), .DEPTH(ML + 1)) u_dly_tgt1 (
		.clk(clk), .ce(ce), .d({r1_s1, r0_s1, c0_s1}), .q(tgt_d1));

	// Leading coefficient.
	q64_t qa_s2, ad_s2, bc_s2, rc_s2;

	always_ff @(posedge clk) begin
		if (ce) begin
			qa_s2 <= sat_sub(ad_m, bc_m);
			ad_s2 <= ad_m;
			bc_s2 <= bc_m;
			rc_s2 <= rc_m;
		end
	end

	// Second multiplier bank: terms of B, and C.
	q64_t m1_m, m2_m, m3_m, qc_m;
	logic [63:0] qa_d2;

	msc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_m1 (
		.clk(clk), .ce(ce), .x(ext64(tgt_d1[31:0])), .y(qa_s2), .p(m1_m));
	msc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_m2 (
		.clk(clk), .ce(ce), .x(ext64(tgt_d1[95:64])), .y(bc_s2), .p(m2_m));
	msc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_m3 (
		.clk(clk), .ce(ce), .x(ext64(tgt_d1[63:32])), .y(ad_s2), .p(m3_m));
	msc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_qc (
		.clk(clk), .ce(ce), .x(rc_s2), .y(ad_s2), .p(qc_m));

	msc_delay #(.WIDTH(WORD_W), .DEPTH(ML)) u_dly_qa2 (
		.clk(clk), .ce(ce), .d(qa_s2), .q(qa_d2));

	q64_t t_s3, m3_s3, qc_s3, qa_s3;
	q64_t qb_s4, qc_s4, qa_s4;

	always_ff @(posedge clk) begin
		if (ce) begin
			t_s3  <= sat_sub(sat_neg(m1_m), m2_m);
			m3_s3 <= m3_m;
			qc_s3 <= qc_m;
			qa_s3 <= qa_d2;
			qb_s4 <= sat_sub(t_s3, m3_s3);
			qc_s4 <= qc_s3;
			qa_s4 <= qa_s3;
		end
	end

	// Third multiplier bank: B*B and A*C.
	q64_t bb_m, ac_m;
	logic [2*WORD_W-1:0] qab_d4;

	msc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_bb (
		.clk(clk), .ce(ce), .x(qb_s4), .y(qb_s4), .p(bb_m));
	msc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_ac (
		.clk(clk), .ce(ce), .x(qa_s4), .y(qc_s4), .p(ac_m));

	msc_delay #(.WIDTH(2 * WORD_W), .DEPTH(ML)) u_dly_qab4 (
		.clk(clk), .ce(ce), .d({qb_s4, qa_s4}), .q(qab_d4));

	q64_t fac_s5, bb_s5, qa_s5, qb_s5;
	q64_t disc_s6, qa_s6, nb_s6;
	logic zero_s6;

	always_ff @(posedge clk) begin
		if (ce) begin
			fac_s5  <= sat_dbl(sat_dbl(ac_m));
			bb_s5   <= bb_m;
			qa_s5   <= qab_d4[63:0];
			qb_s5   <= qab_d4[127:64];
			disc_s6 <= sat_sub(bb_s5, fac_s5);
			qa_s6   <= qa_s5;
			nb_s6   <= sat_neg(qb_s5);
			zero_s6 <= (qa_s5 == '0);
		end
	end

	// Square root of the discriminant; side values wait alongside.
	logic [63:0] s_root;
	logic [2*WORD_W:0] side_d6;

	msc_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk(clk), .ce(ce), .disc(disc_s6), .root(s_root));

	msc_delay #(.WIDTH(2 * WORD_W + 1), .DEPTH(SQRT_LAT)) u_dly_side6 (
		.clk(clk), .ce(ce), .d({zero_s6 | disc_s6[63], nb_s6, qa_s6}), .q(side_d6));

	q64_t n1_s7, n2_s7, qa_s7;
	logic fail_s7;

	always_ff @(posedge clk) begin
		if (ce) begin
			n1_s7   <= sat_sub(side_d6[127:64], s_root);
			n2_s7   <= sat_add(side_d6[127:64], s_root);
			qa_s7   <= side_d6[63:0];
			fail_s7 <= side_d6[128];
		end
	end

	// Both roots.
	q64_t x1_w, x2_w;
	logic fail_d7;

	msc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x1 (
		.clk(clk), .ce(ce), .num(n1_s7), .den(qa_s7), .quo(x1_w));
	msc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x2 (
		.clk(clk), .ce(ce), .num(n2_s7), .den(qa_s7), .quo(x2_w));

	msc_delay #(.WIDTH(1), .DEPTH(DIV_LAT)) u_dly_fail7 (
		.clk(clk), .ce(ce), .d(fail_s7), .q(fail_d7));

	msc_delay #(.WIDTH(3 * DATA_W), .DEPTH(TAIL_LAT)) u_dly_tgt8 (
		.clk(clk), .ce(ce), .d(tgt_d1), .q(tgt_d8));

	// Root choice, differences and output saturation.
	q64_t c0_w, r0_w;
	q64_t x_s8, x_s9, tr_s9, bl_s9;
	q32_t c0_s8, r0_s8, r1_s8, r1_s9;
	logic fail_s8, fail_s9;
	logic [RES_W-1:0] res_s10;

	assign c0_w = ext64(tgt_d8[31:0]);
	assign r0_w = ext64(tgt_d8[63:32]);

	always_ff @(posedge clk) begin
		if (ce) begin
			// The root from -B minus the square root is kept only if it lies in [0, min(c0, r0)].
			x_s8    <= (!x1_w[63] && x1_w <= c0_w && x1_w <= r0_w) ? x1_w : x2_w;
			c0_s8   <= tgt_d8[31:0];
			r0_s8   <= tgt_d8[63:32];
			r1_s8   <= tgt_d8[95:64];
			fail_s8 <= fail_d7;
			x_s9    <= x_s8;
			tr_s9   <= sat_sub(ext64(r0_s8), x_s8);
			bl_s9   <= sat_sub(ext64(c0_s8), x_s8);
			r1_s9   <= r1_s8;
			fail_s9 <= fail_s8;
			if (fail_s9) begin
				res_s10 <= {STATUS_FAIL, {(4*DATA_W){1'b0}}};
			end else begin
				res_s10 <= {STATUS_OK, sat_out32(sat_sub(ext64(r1_s9), bl_s9)),
					sat_out32(bl_s9), sat_out32(tr_s9), sat_out32(x_s9)};
			end
		end
	end

	// Valid bits travel beside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[LAT-1:0], s_axis_tvalid};
		end
	end

	// Two-entry output buffer decouples the receiver from the pipeline.
	logic [RES_W-1:0] obuf_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             push, pop;

	assign ce   = (cnt_q != 2'd2);
	assign push = ce & vld_s[LAT];
	assign pop  = (cnt_q != 2'd0) & m_axis_tready;

	always_ff @(posedge clk) begin
		if (push) begin
			obuf_q[wr_q] <= res_s10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign s_axis_tready = ce;
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = obuf_q[rd_q][4*DATA_W-1:0];
	assign m_axis_tuser  = obuf_q[rd_q][4*DATA_W];

endmodule

`default_nettype wire

[hdl/msc_delay.sv]
// Enabled shift line that keeps side values aligned with the arithmetic units.
`default_nettype none

module msc_delay #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 5
) (
	input  wire logic             clk,
	input  wire logic             ce,
	input  wire logic [WIDTH-1:0] d,
	output logic      [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		if (ce) begin
			tap_s[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule

`default_nettype wire

[hdl/msc_mulq.sv]
// Pipelined fixed-point multiplier: floor(x*y / 2^FRAC_BITS), saturated to 64 bits.
`default_nettype none

module msc_mulq
	import msc_pkg::*;
#(
	parameter int FRAC_BITS = 24
) (
	input  wire logic clk,
	input  wire logic ce,
	input  wire q64_t x,
	input  wire q64_t y,
	output q64_t      p
);

	logic        neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0] xm_s1, ym_s1;
	logic [63:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic [127:0] prod_s3, q_s4;
	q64_t        p_s5;
	logic [127:0] sh;
	logic        rnd;

	always_comb begin
		sh  = prod_s3 >> FRAC_BITS;
		rnd = neg_s3 & (|prod_s3[FRAC_BITS-1:0]);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			neg_s1  <= x[63] ^ y[63];
			xm_s1   <= x[63] ? 64'(-x) : 64'(x);
			ym_s1   <= y[63] ? 64'(-y) : 64'(y);
			neg_s2  <= neg_s1;
			p00_s2  <= xm_s1[31:0]  * ym_s1[31:0];
			p01_s2  <= xm_s1[31:0]  * ym_s1[63:32];
			p10_s2  <= xm_s1[63:32] * ym_s1[31:0];
			p11_s2  <= xm_s1[63:32] * ym_s1[63:32];
			neg_s3  <= neg_s2;
			prod_s3 <= {64'd0, p00_s2} + {32'd0, p01_s2, 32'd0}
				+ {32'd0, p10_s2, 32'd0} + {p11_s2, 64'd0};
			neg_s4  <= neg_s3;
			// Flooring a negative product rounds the magnitude up.
			q_s4    <= sh + {127'd0, rnd};
			if (|q_s4[127:63]) begin
				p_s5 <= neg_s4 ? Q64_MIN : Q64_MAX;
			end else begin
				p_s5 <= neg_s4 ? -q64_t'(q_s4[63:0]) : q64_t'(q_s4[63:0]);
			end
		end
	end

	assign p = p_s5;

endmodule

`default_nettype wire

[hdl/msc_sqrt.sv]
// Pipelined digit-by-digit square root of disc * 2^FRAC_BITS, one root bit per stage.
`default_nettype none

module msc_sqrt
	import msc_pkg::*;
#(
	parameter int FRAC_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        ce,
	input  wire logic [63:0] disc,
	output logic      [63:0] root
);

	localparam int ROOT_W = sqrt_lat(FRAC_BITS);
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 3;

	logic [RAD_W-1:0]  rad_s  [ROOT_W+1];
	logic [REM_W-1:0]  rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];

	always_comb begin
		rad_s[0]  = {{(RAD_W-64){1'b0}}, disc} << FRAC_BITS;
		rem_s[0]  = '0;
		root_s[0] = '0;
	end

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_step
		logic [REM_W-1:0] rsh, trial;
		logic             ge;

		always_comb begin
			rsh   = {rem_s[k-1][REM_W-3:0], rad_s[k-1][RAD_W-1 -: 2]};
			trial = {1'b0, root_s[k-1], 2'b01};
			ge    = (rsh >= trial);
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k]  <= ge ? (rsh - trial) : rsh;
				root_s[k] <= {root_s[k-1][ROOT_W-2:0], ge};
				rad_s[k]  <= rad_s[k-1] << 2;
			end
		end
	end

	assign root = {{(64-ROOT_W){1'b0}}, root_s[ROOT_W]};

endmodule

`default_nettype wire

[hdl/msc_div.sv]
// Pipelined restoring divider: trunc(num * 2^(FRAC_BITS-1) / den), saturated to 64 bits.
`default_nettype none

module msc_div
	import msc_pkg::*;
#(
	parameter int FRAC_BITS = 24
) (
	input  wire logic clk,
	input  wire logic ce,
	input  wire q64_t num,
	input  wire q64_t den,
	output q64_t      quo
);

	localparam int NUM_W = WORD_W + FRAC_BITS - 1;

	logic [NUM_W-1:0] n_s   [NUM_W+1];
	logic [NUM_W-1:0] q_s   [NUM_W+1];
	logic [63:0]      rem_s [NUM_W+1];
	logic [63:0]      d_s   [NUM_W+1];
	logic             neg_s [NUM_W+1];
	q64_t             quo_s;

	always_ff @(posedge clk) begin
		if (ce) begin
			n_s[0]   <= {(num[63] ? 64'(-num) : 64'(num)), {(FRAC_BITS-1){1'b0}}};
			d_s[0]   <= den[63] ? 64'(-den) : 64'(den);
			neg_s[0] <= num[63] ^ den[63];
			rem_s[0] <= '0;
			q_s[0]   <= '0;
		end
	end

	for (genvar k = 1; k <= NUM_W; k++) begin : g_bit
		logic [64:0] rsh, dsub;
		logic        ge;

		always_comb begin
			rsh  = {rem_s[k-1], n_s[k-1][NUM_W-1]};
			dsub = rsh - {1'b0, d_s[k-1]};
			ge   = (rsh >= {1'b0, d_s[k-1]});
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k] <= ge ? dsub[63:0] : rsh[63:0];
				q_s[k]   <= {q_s[k-1][NUM_W-2:0], ge};
				n_s[k]   <= n_s[k-1] << 1;
				d_s[k]   <= d_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			if (|q_s[NUM_W][NUM_W-1:63]) begin
				quo_s <= neg_s[NUM_W] ? Q64_MIN : Q64_MAX;
			end else begin
				quo_s <= neg_s[NUM_W] ? -q64_t'(q_s[NUM_W][63:0])
					: q64_t'(q_s[NUM_W][63:0]);
			end
		end
	end

	assign quo = quo_s;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the 2x2 closed-form matrix scaling pipeline.
`timescale 1ns / 100ps
`default_nettype none

module tb_top
	import msc_pkg::*;
();

	localparam int FB = 24;
	localparam int LATENCY = 15 + (65 + FB) / 2 + (65 + FB) + 10;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [31:0] r1, r0, c0, d, c, b, a;
	} mat_in_t;

	typedef struct packed {
		logic        status;
		logic [31:0] br, bl, tr, tl;
	} scaled_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [223:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic m_axis_tuser;

	scaled_t expected_q[$];
	int errors = 0;
	longint cycles = 0;
	bit hold_off = 0;

	matrix_scale_2x2_closed_form #(.FRAC_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("status: fail");
			$finish;
		end
	end

	// 128-bit exact arithmetic, saturated back to 64 bits.
	function automatic q64_t sat128(input logic signed [127:0] v);
		if (v > 128'sh7FFFFFFFFFFFFFFF) return Q64_MAX;
		if (v < -128'sh8000000000000000) return Q64_MIN;
		return v[63:0];
	endfunction

	function automatic q64_t fx_mul(input q64_t x, input q64_t y);
		logic signed [127:0] p;
		p = 128'(x) * 128'(y);
		return sat128(p >>> FB);
	endfunction

	function automatic q64_t fx_add(input q64_t x, input q64_t y);
		return sat128(128'(x) + 128'(y));
	endfunction

	function automatic q64_t fx_sub(input q64_t x, input q64_t y);
		return sat128(128'(x) - 128'(y));
	endfunction

	function automatic q64_t fx_neg(input q64_t x);
		return sat128(-128'(x));
	endfunction

	function automatic logic [63:0] wide_sqrt(input logic [127:0] v);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if (128'(t) * 128'(t) <= v) r = t;
		end
		return r;
	endfunction

	function automatic q64_t root_quot(input q64_t num, input q64_t den);
		logic signed [127:0] n;
		n = 128'(num) <<< (FB - 1);
		return sat128(n / 128'(den));
	endfunction

	function automatic logic [31:0] clamp32(input q64_t v);
		if (v > 64'sd2147483647) return 32'h7FFFFFFF;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic scaled_t solve_scaling(input mat_in_t m);
		q64_t a, b, c, d, c0, r0, r1, ad, bc, qa, qb, qc, fac, disc, s, nb, x1, x2, x, bl;
		scaled_t r;
		a = 64'(signed'(m.a)); b = 64'(signed'(m.b));
		c = 64'(signed'(m.c)); d = 64'(signed'(m.d));
		c0 = 64'(signed'(m.c0)); r0 = 64'(signed'(m.r0)); r1 = 64'(signed'(m.r1));
		ad = fx_mul(a, d);
		bc = fx_mul(b, c);
		qa = fx_sub(ad, bc);
		qb = fx_sub(fx_sub(fx_neg(fx_mul(c0, qa)), fx_mul(r1, bc)), fx_mul(r0, ad));
		qc = fx_mul(fx_mul(r0, c0), ad);
		fac = fx_mul(qa, qc);
		fac = fx_add(fac, fac);
		fac = fx_add(fac, fac);
		disc = fx_sub(fx_mul(qb, qb), fac);
		r = '0;
		if (qa == 0 || disc < 0) begin
			r.status = STATUS_FAIL;
			return r;
		end
		s = wide_sqrt(128'(disc) << FB);
		nb = fx_neg(qb);
		x1 = root_quot(fx_sub(nb, s), qa);
		x2 = root_quot(fx_add(nb, s), qa);
		x = (x1 >= 0 && x1 <= c0 && x1 <= r0) ? x1 : x2;
		bl = fx_sub(c0, x);
		r.status = STATUS_OK;
		r.tl = clamp32(x);
		r.tr = clamp32(fx_sub(r0, x));
		r.bl = clamp32(bl);
		r.br = clamp32(fx_sub(r1, bl));
		return r;
	endfunction

	task automatic send_matrix(input mat_in_t m);
		s_axis_tdata <= m;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		expected_q.push_back(solve_scaling(m));
		@(negedge clk);
	endtask

	task automatic idle_gap(input int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic logic [31:0] q(input real v);
		return 32'($rtoi(v * 16777216.0));
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom;
			default: return 32'($urandom_range(0, 32'h04000000)) - 32'h02000000;
		endcase
	endfunction

	// Positive matrix with targets in a consistent range, so a real root is found.
	function automatic mat_in_t well_formed();
		mat_in_t m;
		m.a = $urandom_range(32'h00100000, 32'h04000000);
		m.b = $urandom_range(32'h00100000, 32'h04000000);
		m.c = $urandom_range(32'h00100000, 32'h04000000);
		m.d = $urandom_range(32'h00100000, 32'h04000000);
		m.r0 = $urandom_range(32'h00400000, 32'h03000000);
		m.r1 = $urandom_range(32'h00400000, 32'h03000000);
		m.c0 = $urandom_range(32'h00200000, 32'h03000000);
		return m;
	endfunction

	task automatic test_directed();
		mat_in_t m;
		// Identity with unit targets; patterns list r1, r0, c0, d, c, b, a.
		send_matrix('{q(1), q(1), q(1), q(1), q(0), q(0), q(1)});
		// Singular matrix: zero leading coefficient.
		send_matrix('{q(2), q(2), q(2), q(1), q(1), q(1), q(1)});
		send_matrix('0);
		// Unit targets on a matrix with d = 2, and a general positive case.
		send_matrix('{q(1), q(1), q(1), q(2), q(1), q(1), q(1)});
		send_matrix('{q(0.5), q(1.5), q(1), q(2), q(0.8), q(1.2), q(1.3)});
		// Negative entries or targets, a zero discriminant and root fallback candidates.
		send_matrix('{q(1), q(3), q(-2), q(1), q(-1), q(2), q(1)});
		send_matrix('{q(2), q(1), q(1), q(1), q(-1), q(-1), q(5)});
		send_matrix('{q(0.5), q(1), q(1), q(0.5), q(0), q(0), q(1)});
		// Extreme and smallest-magnitude entries and targets.
		send_matrix({7{32'h7FFFFFFF}});
		send_matrix({7{32'h80000000}});
		send_matrix({32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000});
		send_matrix({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
		send_matrix({7{32'hFFFFFFFF}});
		send_matrix({7{32'h00000001}});
		m = '{q(100), q(0.001), q(0.001), q(100), q(120), q(-120), q(120)};
		send_matrix(m);
		idle_gap(1);
	endtask

	task automatic test_random(input int count);
		mat_in_t m;
		int burst;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst && sent < count; i++) begin
				if ($urandom_range(0, 9) < 7) m = well_formed();
				else m = {rand_word(), rand_word(), rand_word(), rand_word(),
					rand_word(), rand_word(), rand_word()};
				send_matrix(m);
				sent++;
			end
			if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
		end
		idle_gap(1);
	endtask

	// Receiver stays off long enough for the pipeline and buffer to fill.
	task automatic test_backpressure();
		hold_off = 1;
		for (int i = 0; i < 200; i++) send_matrix(well_formed());
		idle_gap(1);
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_off) begin
			m_axis_tready <= 1'b0;
			repeat (LATENCY + 300) @(negedge clk);
			hold_off = 0;
		end else if (cycles % 2000 < 700) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		scaled_t got;
		scaled_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata};
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (got.tl !== want.tl) begin
					$display("%0t top_left exp %h got %h", $time, want.tl, got.tl);
					errors++;
				end
				if (got.tr !== want.tr) begin
					$display("%0t top_right exp %h got %h", $time, want.tr, got.tr);
					errors++;
				end
				if (got.bl !== want.bl) begin
					$display("%0t bottom_left exp %h got %h", $time, want.bl, got.bl);
					errors++;
				end
				if (got.br !== want.br) begin
					$display("%0t bottom_right exp %h got %h", $time, want.br, got.br);
					errors++;
				end
				if (got.status !== want.status) begin
					$display("%0t status exp %b got %b", $time, want.status, got.status);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(500);
		test_backpressure();
		test_random(450);
		drain();
		if (expected_q.size() != 0) begin
			$display("%0t %0d results missing", $time, expected_q.size());
			errors++;
		end
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

[matrix_scale_2x2_closed_form.f]
hdl/msc_pkg.sv
hdl/msc_delay.sv
hdl/msc_mulq.sv
hdl/msc_sqrt.sv
hdl/msc_div.sv
hdl/matrix_scale_2x2_closed_form.sv
sim/tb_top.sv
